// ----- hw/rtl/ihpq_pkg.sv -----
`default_nettype none
package ihpq_pkg;

    localparam int KEY_BITS   = 12;
    localparam int LIMIT_BITS = 13;
    localparam int SLOTS_BITS = 9;
    localparam int CFG_BITS   = 13;

    localparam logic [1:0] CMD_ADD    = 2'd0;
    localparam logic [1:0] CMD_REMOVE = 2'd1;

    localparam logic CFG_KEY_LIMIT  = 1'b0;
    localparam logic CFG_HEAP_SLOTS = 1'b1;

    // datapath micro-operations
    localparam logic [4:0] OP_NOP       = 5'd0;
    localparam logic [4:0] OP_CLR       = 5'd1;
    localparam logic [4:0] OP_LOAD      = 5'd2;
    localparam logic [4:0] OP_REJ       = 5'd3;
    localparam logic [4:0] OP_RD_POS    = 5'd4;
    localparam logic [4:0] OP_RD_HIT    = 5'd5;
    localparam logic [4:0] OP_RD_EVICT  = 5'd6;
    localparam logic [4:0] OP_ADD_NEW   = 5'd7;
    localparam logic [4:0] OP_RAISE     = 5'd8;
    localparam logic [4:0] OP_EVICT_CLR = 5'd9;
    localparam logic [4:0] OP_ADD_LAST  = 5'd10;
    localparam logic [4:0] OP_RD_LAST   = 5'd11;
    localparam logic [4:0] OP_RM_ROOT   = 5'd12;
    localparam logic [4:0] OP_RM_DROP   = 5'd13;
    localparam logic [4:0] OP_RM_MOVE   = 5'd14;
    localparam logic [4:0] OP_RD_P      = 5'd15;
    localparam logic [4:0] OP_RD_C      = 5'd16;
    localparam logic [4:0] OP_LATCH_C   = 5'd17;
    localparam logic [4:0] OP_PICK_R    = 5'd18;
    localparam logic [4:0] OP_SW1       = 5'd19;
    localparam logic [4:0] OP_SW2_DN    = 5'd20;
    localparam logic [4:0] OP_SW2_UP    = 5'd21;
    localparam logic [4:0] OP_RD_PAR    = 5'd22;
    localparam logic [4:0] OP_LATCH_PAR = 5'd23;
    localparam logic [4:0] OP_POP       = 5'd24;
    localparam logic [4:0] OP_RD_ROOT   = 5'd25;
    localparam logic [4:0] OP_OUT       = 5'd26;

    typedef struct packed {
        logic [4:0] op;
    } ihpq_cmd_t;

    typedef struct packed {
        logic clr_last;
        logic is_add;
        logic is_rm;
        logic rej_add;
        logic cnt_zero;
        logic pos_hit;
        logic full;
        logic cnt_ge2;
        logic down_ok;
        logic two_kids;
        logic pick_right;
        logic dn_less;
        logic p_ge2;
        logic up_greater;
        logic sp_zero;
        logic out_free;
    } ihpq_status_t;

endpackage
`default_nettype wire

// ----- hw/rtl/ihpq_ctrl.sv -----
`default_nettype none
module ihpq_ctrl
    import ihpq_pkg::*;
(
    input  wire          aclk,
    input  wire          aresetn,
    input  wire          s_tvalid,
    output logic         s_tready,
    input  ihpq_status_t st,
    output ihpq_cmd_t    cmd
);

    localparam logic [4:0] ST_CLR      = 5'd0;
    localparam logic [4:0] ST_IDLE     = 5'd1;
    localparam logic [4:0] ST_DISP     = 5'd2;
    localparam logic [4:0] ST_ADD_POS  = 5'd3;
    localparam logic [4:0] ST_RAISE    = 5'd4;
    localparam logic [4:0] ST_EVICT    = 5'd5;
    localparam logic [4:0] ST_EVICT2   = 5'd6;
    localparam logic [4:0] ST_RM_LAST  = 5'd7;
    localparam logic [4:0] ST_RM_DROP  = 5'd8;
    localparam logic [4:0] ST_RM_MOVE  = 5'd9;
    localparam logic [4:0] ST_SD0      = 5'd10;
    localparam logic [4:0] ST_SD1      = 5'd11;
    localparam logic [4:0] ST_SD2      = 5'd12;
    localparam logic [4:0] ST_SD3      = 5'd13;
    localparam logic [4:0] ST_SD4      = 5'd14;
    localparam logic [4:0] ST_SWD2     = 5'd15;
    localparam logic [4:0] ST_SU0      = 5'd16;
    localparam logic [4:0] ST_SU1      = 5'd17;
    localparam logic [4:0] ST_SU2      = 5'd18;
    localparam logic [4:0] ST_SU3      = 5'd19;
    localparam logic [4:0] ST_SWU2     = 5'd20;
    localparam logic [4:0] ST_RET      = 5'd21;
    localparam logic [4:0] ST_FIN      = 5'd22;
    localparam logic [4:0] ST_OUT      = 5'd23;

    logic [4:0] state_reg, state_next;

    assign s_tready = (state_reg == ST_IDLE);

    always_comb begin
        state_next = state_reg;
        cmd.op     = OP_NOP;
        case (state_reg)
            ST_CLR: begin
                cmd.op = OP_CLR;
                if (st.clr_last) state_next = ST_IDLE;
            end
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.op     = OP_LOAD;
                    state_next = ST_DISP;
                end
            end
            ST_DISP: begin
                state_next = ST_FIN;
                if (st.is_add) begin
                    if (st.rej_add) begin
                        cmd.op = OP_REJ;
                    end else begin
                        cmd.op     = OP_RD_POS;
                        state_next = ST_ADD_POS;
                    end
                end else if (st.is_rm) begin
                    if (st.cnt_zero) begin
                        cmd.op = OP_REJ;
                    end else begin
                        cmd.op     = OP_RD_LAST;
                        state_next = ST_RM_LAST;
                    end
                end
            end
            ST_ADD_POS: begin
                if (st.pos_hit) begin
                    cmd.op     = OP_RD_HIT;
                    state_next = ST_RAISE;
                end else if (st.full) begin
                    cmd.op     = OP_RD_EVICT;
                    state_next = ST_EVICT;
                end else begin
                    cmd.op     = OP_ADD_NEW;
                    state_next = ST_SD0;
                end
            end
            ST_RAISE: begin
                cmd.op     = OP_RAISE;
                state_next = ST_SD0;
            end
            ST_EVICT: begin
                cmd.op     = OP_EVICT_CLR;
                state_next = ST_EVICT2;
            end
            ST_EVICT2: begin
                cmd.op     = OP_ADD_LAST;
                state_next = ST_SD0;
            end
            ST_RM_LAST: begin
                cmd.op     = OP_RM_ROOT;
                state_next = ST_RM_DROP;
            end
            ST_RM_DROP: begin
                cmd.op     = OP_RM_DROP;
                state_next = st.cnt_ge2 ? ST_RM_MOVE : ST_FIN;
            end
            ST_RM_MOVE: begin
                cmd.op     = OP_RM_MOVE;
                state_next = ST_SD0;
            end
            ST_SD0: begin
                if (st.down_ok) begin
                    cmd.op     = OP_RD_P;
                    state_next = ST_SD1;
                end else begin
                    state_next = ST_SU0;
                end
            end
            ST_SD1: begin
                cmd.op     = OP_RD_C;
                state_next = ST_SD2;
            end
            ST_SD2: begin
                cmd.op     = OP_LATCH_C;
                state_next = st.two_kids ? ST_SD3 : ST_SD4;
            end
            ST_SD3: begin
                if (st.pick_right) cmd.op = OP_PICK_R;
                state_next = ST_SD4;
            end
            ST_SD4: begin
                if (st.dn_less) begin
                    cmd.op     = OP_SW1;
                    state_next = ST_SWD2;
                end else begin
                    state_next = ST_SU0;
                end
            end
            ST_SWD2: begin
                cmd.op     = OP_SW2_DN;
                state_next = ST_SD0;
            end
            ST_SU0: begin
                if (st.p_ge2) begin
                    cmd.op     = OP_RD_P;
                    state_next = ST_SU1;
                end else begin
                    state_next = ST_RET;
                end
            end
            ST_SU1: begin
                cmd.op     = OP_RD_PAR;
                state_next = ST_SU2;
            end
            ST_SU2: begin
                cmd.op     = OP_LATCH_PAR;
                state_next = ST_SU3;
            end
            ST_SU3: begin
                if (st.up_greater) begin
                    cmd.op     = OP_SW1;
                    state_next = ST_SWU2;
                end else begin
                    state_next = ST_RET;
                end
            end
            ST_SWU2: begin
                cmd.op     = OP_SW2_UP;
                state_next = ST_SD0;
            end
            ST_RET: begin
                // resume the up step of the caller that went down
                if (st.sp_zero) begin
                    state_next = ST_FIN;
                end else begin
                    cmd.op     = OP_POP;
                    state_next = ST_SU0;
                end
            end
            ST_FIN: begin
                cmd.op     = OP_RD_ROOT;
                state_next = ST_OUT;
            end
            ST_OUT: begin
                if (st.out_free) begin
                    cmd.op     = OP_OUT;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_CLR;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLR;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule
`default_nettype wire

// ----- hw/rtl/ihpq_dp.sv -----
`default_nettype none
module ihpq_dp
    import ihpq_pkg::*;
#(
    parameter int MAX_SLOTS      = 256,
    parameter int KEY_SPACE      = 4096,
    parameter int PRIORITY_WIDTH = 16
) (
    input  wire                  aclk,
    input  wire                  aresetn,
    input  ihpq_cmd_t            cmd,
    output ihpq_status_t         st,
    input  wire                  cfg_wr_en,
    input  wire                  cfg_addr,
    input  wire  [CFG_BITS-1:0]  cfg_wdata,
    input  wire  [1:0]           in_command,
    input  wire  [15:0]          in_priority,
    input  wire  [KEY_BITS-1:0]  in_key,
    output logic                 m_tvalid,
    input  wire                  m_tready,
    output logic [39:0]          m_tdata
);

    localparam int SW  = $clog2(MAX_SLOTS);
    localparam int KW  = $clog2(KEY_SPACE);
    localparam int PW  = PRIORITY_WIDTH;
    localparam int EW  = PW + KEY_BITS;
    localparam int SD  = 2 * SW;
    localparam int SIW = $clog2(SD);
    localparam int SPW = $clog2(SD + 1);

    logic [EW-1:0] hmem [MAX_SLOTS];
    logic [SW-1:0] pmem [KEY_SPACE];

    logic [1:0]            cmd_reg;
    logic [PW-1:0]         prio_reg;
    logic [KEY_BITS-1:0]   key_reg;
    logic [SW-1:0]         cnt_reg, p_reg, c_reg;
    logic [EW-1:0]         a_reg, b_reg, hrd_reg;
    logic [SW-1:0]         prd_reg;
    logic [SW-1:0]         stk_reg [SD];
    logic [SPW-1:0]        sp_reg;
    logic [KW-1:0]         clr_reg;
    logic                  rej_reg, evi_reg;
    logic [LIMIT_BITS-1:0] limit_reg;
    logic [SLOTS_BITS-1:0] slots_reg, slots_eff;
    logic [39:0]           out_reg;
    logic                  out_vld_reg;

    logic          hwe, hre, pwe, pre;
    logic [SW-1:0] hwa, hra;
    logic [EW-1:0] hwd;
    logic [KW-1:0] pwa, pra;
    logic [SW-1:0] pwd;

    logic [9:0] c_ext, c1_ext, cnt_ext, slots_ext;
    logic [PW-1:0] a_pr, b_pr, h_pr;
    logic [KEY_BITS-1:0] a_key, b_key, h_key;
    logic [KW-1:0] key_idx;
    logic out_free;

    assign a_pr  = a_reg[PW-1:0];
    assign b_pr  = b_reg[PW-1:0];
    assign h_pr  = hrd_reg[PW-1:0];
    assign a_key = a_reg[EW-1:PW];
    assign b_key = b_reg[EW-1:PW];
    assign h_key = hrd_reg[EW-1:PW];
    assign key_idx = KW'(32'(key_reg));

    assign c_ext     = 10'(p_reg) << 1;
    assign c1_ext    = c_ext + 10'd1;
    assign cnt_ext   = 10'(cnt_reg);
    assign slots_ext = 10'(slots_eff);
    assign out_free  = !out_vld_reg || m_tready;

    always_comb begin
        if (slots_reg < SLOTS_BITS'(2)) begin
            slots_eff = SLOTS_BITS'(2);
        end else if (32'(slots_reg) > MAX_SLOTS) begin
            slots_eff = SLOTS_BITS'(MAX_SLOTS);
        end else begin
            slots_eff = slots_reg;
        end
    end

    always_comb begin
        st.clr_last   = (32'(clr_reg) == KEY_SPACE - 1);
        st.is_add     = (cmd_reg == CMD_ADD);
        st.is_rm      = (cmd_reg == CMD_REMOVE);
        st.rej_add    = (13'(key_reg) >= limit_reg) || (32'(key_reg) >= KEY_SPACE);
        st.cnt_zero   = (cnt_reg == '0);
        st.pos_hit    = (prd_reg != '0) && (prd_reg <= cnt_reg);
        st.full       = (cnt_ext + 10'd1 >= slots_ext);
        st.cnt_ge2    = (cnt_reg >= SW'(2));
        st.down_ok    = (c_ext < slots_ext) && (c_ext <= cnt_ext) &&
                        (32'(c_ext) < MAX_SLOTS);
        st.two_kids   = (c1_ext <= cnt_ext) && (32'(c1_ext) < MAX_SLOTS);
        st.pick_right = !(b_pr > h_pr);
        st.dn_less    = (a_pr < b_pr);
        st.p_ge2      = (p_reg >= SW'(2));
        st.up_greater = (a_pr > b_pr);
        st.sp_zero    = (sp_reg == '0);
        st.out_free   = out_free;
    end

    // memory port muxing per micro-operation
    always_comb begin
        hwe = 1'b0; hwa = p_reg; hwd = b_reg;
        hre = 1'b0; hra = p_reg;
        pwe = 1'b0; pwa = key_idx; pwd = '0;
        pre = 1'b0; pra = key_idx;
        case (cmd.op)
            OP_CLR: begin
                pwe = 1'b1; pwa = clr_reg;
            end
            OP_RD_POS: pre = 1'b1;
            OP_RD_HIT: begin
                hre = 1'b1; hra = prd_reg;
            end
            OP_RD_EVICT, OP_RD_LAST: begin
                hre = 1'b1; hra = cnt_reg;
            end
            OP_ADD_NEW: begin
                hwe = 1'b1; hwa = cnt_reg + SW'(1); hwd = {key_reg, prio_reg};
                pwe = 1'b1; pwd = cnt_reg + SW'(1);
            end
            OP_RAISE: begin
                hwe = 1'b1;
                hwd = {h_key, (h_pr < prio_reg) ? prio_reg : h_pr};
            end
            OP_EVICT_CLR, OP_RM_DROP: begin
                pwe = 1'b1; pwa = KW'(32'(h_key));
            end
            OP_ADD_LAST: begin
                hwe = 1'b1; hwa = cnt_reg; hwd = {key_reg, prio_reg};
                pwe = 1'b1; pwd = cnt_reg;
            end
            OP_RM_ROOT, OP_RD_ROOT: begin
                hre = 1'b1; hra = SW'(1);
            end
            OP_RM_MOVE: begin
                hwe = 1'b1; hwa = SW'(1); hwd = b_reg;
                pwe = 1'b1; pwa = KW'(32'(b_key)); pwd = SW'(1);
            end
            OP_RD_P: hre = 1'b1;
            OP_RD_C: begin
                hre = 1'b1; hra = SW'(c_ext);
            end
            OP_LATCH_C: begin
                hre = 1'b1; hra = SW'(c1_ext);
            end
            OP_SW1: begin
                hwe = 1'b1;
                pwe = 1'b1; pwa = KW'(32'(b_key)); pwd = p_reg;
            end
            OP_SW2_DN, OP_SW2_UP: begin
                hwe = 1'b1; hwa = c_reg; hwd = a_reg;
                pwe = 1'b1; pwa = KW'(32'(a_key)); pwd = c_reg;
            end
            OP_RD_PAR: begin
                hre = 1'b1; hra = p_reg >> 1;
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (hwe) hmem[hwa] <= hwd;
        if (hre) hrd_reg <= hmem[hra];
    end

    always_ff @(posedge aclk) begin
        if (pwe) pmem[pwa] <= pwd;
        if (pre) prd_reg <= pmem[pra];
    end

    // payload and working registers
    always_ff @(posedge aclk) begin
        case (cmd.op)
            OP_LOAD: begin
                cmd_reg  <= in_command;
                prio_reg <= PW'(32'(in_priority));
                key_reg  <= in_key;
            end
            OP_RD_HIT:    p_reg <= prd_reg;
            OP_ADD_NEW:   p_reg <= cnt_reg + SW'(1);
            OP_ADD_LAST:  p_reg <= cnt_reg;
            OP_RM_ROOT:   b_reg <= hrd_reg;
            OP_RM_MOVE:   p_reg <= SW'(1);
            OP_RD_C:      a_reg <= hrd_reg;
            OP_LATCH_C: begin
                b_reg <= hrd_reg;
                c_reg <= SW'(c_ext);
            end
            OP_PICK_R: begin
                b_reg <= hrd_reg;
                c_reg <= SW'(c1_ext);
            end
            OP_SW2_DN: begin
                if (sp_reg < SPW'(SD)) stk_reg[sp_reg[SIW-1:0]] <= p_reg;
                p_reg <= c_reg;
            end
            OP_SW2_UP:    p_reg <= c_reg;
            OP_RD_PAR:    a_reg <= hrd_reg;
            OP_LATCH_PAR: begin
                b_reg <= hrd_reg;
                c_reg <= p_reg >> 1;
            end
            OP_POP:       p_reg <= stk_reg[SIW'(sp_reg - SPW'(1))];
            default: ;
        endcase
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg     <= '0;
            sp_reg      <= '0;
            clr_reg     <= '0;
            rej_reg     <= 1'b0;
            evi_reg     <= 1'b0;
            limit_reg   <= LIMIT_BITS'(4096);
            slots_reg   <= SLOTS_BITS'(256);
            out_vld_reg <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                case (cfg_addr)
                    CFG_KEY_LIMIT:  limit_reg <= cfg_wdata[LIMIT_BITS-1:0];
                    CFG_HEAP_SLOTS: slots_reg <= cfg_wdata[SLOTS_BITS-1:0];
                    default: ;
                endcase
            end
            if (cmd.op == OP_OUT) begin
                out_vld_reg <= 1'b1;
            end else if (out_vld_reg && m_tready) begin
                out_vld_reg <= 1'b0;
            end
            case (cmd.op)
                OP_CLR:      clr_reg <= clr_reg + KW'(1);
                OP_LOAD: begin
                    rej_reg <= 1'b0;
                    evi_reg <= 1'b0;
                    sp_reg  <= '0;
                end
                OP_REJ:      rej_reg <= 1'b1;
                OP_RD_EVICT: evi_reg <= 1'b1;
                OP_ADD_NEW:  cnt_reg <= cnt_reg + SW'(1);
                OP_RM_DROP:  cnt_reg <= cnt_reg - SW'(1);
                OP_SW2_DN: begin
                    if (sp_reg < SPW'(SD)) sp_reg <= sp_reg + SPW'(1);
                end
                OP_POP:      sp_reg <= sp_reg - SPW'(1);
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.op == OP_OUT) begin
            out_reg <= {1'b0, evi_reg, rej_reg, 8'(cnt_reg),
                        (cnt_reg != '0) ? h_key : {KEY_BITS{1'b0}},
                        (cnt_reg != '0) ? 16'(32'(h_pr)) : 16'd0,
                        (cnt_reg != '0)};
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = out_reg;

`ifndef SYNTHESIS
    a_sp_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        32'(sp_reg) <= SD)
        else $error("sift stack pointer out of range");
    a_out_free: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.op == OP_OUT) |-> out_free)
        else $error("result overwritten before taken");
    a_flags: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.op == OP_OUT) |-> !(rej_reg && evi_reg))
        else $error("rejected and evicted both set");
    a_add_cnt: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.op == OP_ADD_NEW) |=> (cnt_reg == $past(cnt_reg) + SW'(1)))
        else $error("count did not advance on new key");
    a_cnt_range: assert property (@(posedge aclk) disable iff (!aresetn)
        32'(cnt_reg) < MAX_SLOTS)
        else $error("entry count beyond slot range");
`endif

endmodule
`default_nettype wire

// ----- hw/rtl/indexed_max_heap_priority_queue.sv -----
`default_nettype none
// Indexed binary max-heap of (priority, key) entries with a key-to-slot map.
// After reset all KEY_SPACE entries of the position map (4096 by default) are
// cleared before the first item is taken; configuration writes work meanwhile.
// One item is processed at a time: a peek or a rejected item goes straight to
// its result, an add or remove also sifts its entry through the heap, and every
// heap level an entry moves costs a sift step that reads, compares and writes
// back through heap and map memories with one read and one write port each.
// A result is held in an output register until taken; the next item is
// accepted once the result has been registered.
module indexed_max_heap_priority_queue
    import ihpq_pkg::*;
#(
    parameter int MAX_SLOTS      = 256,
    parameter int KEY_SPACE      = 4096,
    parameter int PRIORITY_WIDTH = 16
) (
    input  wire                 aclk,
    input  wire                 aresetn,
    input  wire                 cfg_wr_en,
    input  wire                 cfg_addr,
    input  wire  [CFG_BITS-1:0] cfg_wdata,
    input  wire                 s_tvalid,
    output logic                s_tready,
    input  wire  [31:0]         s_tdata,  // priority_req[15:0], key[27:16]
    input  wire  [1:0]          s_tuser,  // command[1:0]
    output logic                m_tvalid,
    input  wire                 m_tready,
    // nonempty[0], top_priority[16:1], top_key[28:17], entry_count[36:29],
    // rejected[37], evicted[38]
    output logic [39:0]         m_tdata
);

    ihpq_cmd_t    cmd;
    ihpq_status_t st;

    ihpq_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .st       (st),
        .cmd      (cmd)
    );

    ihpq_dp #(
        .MAX_SLOTS      (MAX_SLOTS),
        .KEY_SPACE      (KEY_SPACE),
        .PRIORITY_WIDTH (PRIORITY_WIDTH)
    ) u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (cmd),
        .st          (st),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_addr    (cfg_addr),
        .cfg_wdata   (cfg_wdata),
        .in_command  (s_tuser),
        .in_priority (s_tdata[15:0]),
        .in_key      (s_tdata[27:16]),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)
    );

endmodule
`default_nettype wire
